// File: hdl/wesm_pkg.sv
package wesm_pkg;

   // Fixed field and register widths
   localparam int CFG_W      = 24;
   localparam int VPP_W      = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int VEL_W      = 48;
   localparam int DIST_W     = 48;
   localparam int PULSES_W   = 16;

   // Register indexes of the configuration port
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WINDOW_TICKS  = 2'd0,
      CSR_STALL_TIMEOUT = 2'd1,
      CSR_MM_PER_PULSE  = 2'd2,
      CSR_VEL_PER_PULSE = 2'd3
   } csr_index_type;

   // Reset values of the configuration registers
   localparam logic [CFG_W-1:0] WINDOW_TICKS_RST  = 24'd50000;
   localparam logic [CFG_W-1:0] STALL_TIMEOUT_RST = 24'd300000;
   localparam logic [CFG_W-1:0] MM_PER_PULSE_RST  = 24'd40554;
   localparam logic [VPP_W-1:0] VEL_PER_PULSE_RST = 32'd811082;

   // Saturation limits of the 48-bit results and the 16-bit pulse count
   localparam logic [VEL_W-1:0]    VAL48_MAX  = '1;
   localparam logic [PULSES_W-1:0] PULSES_MAX = '1;

   // Configuration register set
   typedef struct packed {
      logic [CFG_W-1:0] window_ticks;
      logic [CFG_W-1:0] stall_timeout_ticks;
      logic [CFG_W-1:0] mm_per_pulse;
      logic [VPP_W-1:0] velocity_per_pulse;
   } cfg_type;

   // Control flags of one pipeline transaction
   typedef struct packed {
      logic valid;
      logic clear;
      logic stopped;
   } event_type;

endpackage

// File: hdl/wesm_req_if.sv
interface wesm_req_if;
   logic valid;
   logic ready;
   logic command;
   logic edge_req;

   modport source (output valid, output command, output edge_req, input ready);
   modport sink (input valid, input command, input edge_req, output ready);
endinterface

// File: hdl/wesm_rsp_if.sv
interface wesm_rsp_if
   import wesm_pkg::*;
;
   logic                valid;
   logic                ready;
   logic [VEL_W-1:0]    velocity;
   logic [DIST_W-1:0]   distance;
   logic [PULSES_W-1:0] window_pulses;
   logic                stopped;

   modport source (output valid, output velocity, output distance,
                   output window_pulses, output stopped, input ready);
   modport sink (input valid, input velocity, input distance,
                 input window_pulses, input stopped, output ready);
endinterface

// File: hdl/wesm_csr.sv
module wesm_csr
   import wesm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output cfg_type               cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // Register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wr_en) begin
         unique case (csr_index_type'(csr_index))
            CSR_WINDOW_TICKS:  cfg_in.window_ticks        = csr_wr_data[CFG_W-1:0];
            CSR_STALL_TIMEOUT: cfg_in.stall_timeout_ticks = csr_wr_data[CFG_W-1:0];
            CSR_MM_PER_PULSE:  cfg_in.mm_per_pulse        = csr_wr_data[CFG_W-1:0];
            CSR_VEL_PER_PULSE: cfg_in.velocity_per_pulse  = csr_wr_data[VPP_W-1:0];
            default:           cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_ticks        <= WINDOW_TICKS_RST;
         cfg_ff.stall_timeout_ticks <= STALL_TIMEOUT_RST;
         cfg_ff.mm_per_pulse        <= MM_PER_PULSE_RST;
         cfg_ff.velocity_per_pulse  <= VEL_PER_PULSE_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: hdl/wesm_window_counter.sv
module wesm_window_counter
   import wesm_pkg::*;
#(
   parameter int COUNT_WIDTH        = 16,
   parameter int TICK_COUNTER_WIDTH = 24
) (
   input  logic                   clock,
   input  logic                   reset,
   wesm_req_if.sink               req,
   input  cfg_type                cfg,
   input  logic                   ev_take,
   output event_type              ev,
   output logic [COUNT_WIDTH-1:0] ev_count
);

   localparam int CW = COUNT_WIDTH;
   localparam int TW = TICK_COUNTER_WIDTH;
   localparam int SW = TICK_COUNTER_WIDTH + 1;

   logic [TW-1:0] wtc_ff, wtc_in, wtc_step;
   logic [CW-1:0] pc_ff, pc_in, pc_step;
   logic [SW-1:0] since_ff, since_in, since_step;
   event_type     ev_ff, ev_in;
   logic [CW-1:0] ev_count_ff, ev_count_in;
   logic          accept;
   logic          close;
   logic          stopped_now;

   // One slot of event storage; ticks that close no window need none but wait alike
   assign req.ready = !ev_ff.valid || ev_take;
   assign accept    = req.valid && req.ready;

   // Saturating counter steps for this tick
   always_comb begin
      pc_step     = (req.edge_req && (pc_ff != '1)) ? pc_ff + CW'(1) : pc_ff;
      since_step  = req.edge_req ? '0 :
                    ((since_ff != '1) ? since_ff + SW'(1) : since_ff);
      wtc_step    = (wtc_ff != '1) ? wtc_ff + TW'(1) : wtc_ff;
      close       = 32'(wtc_step) >= 32'(cfg.window_ticks);
      stopped_now = 33'(since_step) > 33'(cfg.stall_timeout_ticks);
   end

   // Counter update and window-close event
   always_comb begin
      wtc_in      = wtc_ff;
      pc_in       = pc_ff;
      since_in    = since_ff;
      ev_in       = ev_ff;
      ev_count_in = ev_count_ff;
      if (ev_take) begin
         ev_in.valid = 1'b0;
      end
      if (accept) begin
         if (req.command) begin
            wtc_in      = '0;
            pc_in       = '0;
            since_in    = '0;
            ev_in       = '{valid: 1'b1, clear: 1'b1, stopped: 1'b0};
            ev_count_in = '0;
         end else begin
            wtc_in   = wtc_step;
            pc_in    = pc_step;
            since_in = since_step;
            if (close) begin
               wtc_in      = '0;
               pc_in       = '0;
               ev_in       = '{valid: 1'b1, clear: 1'b0, stopped: stopped_now};
               ev_count_in = pc_step;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wtc_ff   <= '0;
         pc_ff    <= '0;
         since_ff <= '0;
         ev_ff    <= '0;
      end else begin
         wtc_ff   <= wtc_in;
         pc_ff    <= pc_in;
         since_ff <= since_in;
         ev_ff    <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      ev_count_ff <= ev_count_in;
   end

   assign ev       = ev_ff;
   assign ev_count = ev_count_ff;

endmodule

// File: hdl/wesm_product.sv
module wesm_product
   import wesm_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  cfg_type                       cfg,
   input  event_type                     ev,
   input  logic [COUNT_WIDTH-1:0]        ev_count,
   output logic                          ev_take,
   input  logic                          prod_take,
   output event_type                     prod_ev,
   output logic [COUNT_WIDTH-1:0]        prod_count,
   output logic [COUNT_WIDTH+VPP_W-1:0]  vel_prod,
   output logic [COUNT_WIDTH+CFG_W-1:0]  dist_prod
);

   localparam int CW = COUNT_WIDTH;
   localparam int VW = COUNT_WIDTH + VPP_W;
   localparam int DW = COUNT_WIDTH + CFG_W;

   event_type     ev_ff, ev_in;
   logic [CW-1:0] count_ff;
   logic [VW-1:0] vel_ff, vel_in;
   logic [DW-1:0] dist_ff, dist_in;

   assign ev_take = ev.valid && (!ev_ff.valid || prod_take);

   // Edge count times per-edge velocity and distance
   always_comb begin
      vel_in  = VW'(ev_count) * VW'(cfg.velocity_per_pulse);
      dist_in = DW'(ev_count) * DW'(cfg.mm_per_pulse);
      ev_in   = ev_ff;
      if (prod_take) begin
         ev_in.valid = 1'b0;
      end
      if (ev_take) begin
         ev_in = ev;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ev_ff <= '0;
      end else begin
         ev_ff <= ev_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ev_take) begin
         count_ff <= ev_count;
         vel_ff   <= vel_in;
         dist_ff  <= dist_in;
      end
   end

   assign prod_ev    = ev_ff;
   assign prod_count = count_ff;
   assign vel_prod   = vel_ff;
   assign dist_prod  = dist_ff;

endmodule

// File: hdl/wesm_result.sv
module wesm_result
   import wesm_pkg::*;
#(
   parameter int COUNT_WIDTH = 16
) (
   input  logic                          clock,
   input  logic                          reset,
   input  event_type                     prod_ev,
   input  logic [COUNT_WIDTH-1:0]        prod_count,
   input  logic [COUNT_WIDTH+VPP_W-1:0]  vel_prod,
   input  logic [COUNT_WIDTH+CFG_W-1:0]  dist_prod,
   output logic                          prod_take,
   wesm_rsp_if.source                    rsp
);

   localparam int DW    = COUNT_WIDTH + CFG_W;
   localparam int SUM_W = ((DW > DIST_W) ? DW : DIST_W) + 1;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [VEL_W-1:0]    velocity_ff, vel_sat;
   logic [DIST_W-1:0]   distance_ff;
   logic [PULSES_W-1:0] pulses_ff, pulses_sat;
   logic                stopped_ff;
   logic [DIST_W-1:0]   dist_acc_ff, dist_acc_in, dist_sat;
   logic [SUM_W-1:0]    dist_sum;

   assign prod_take = prod_ev.valid && (!rsp_valid_ff || rsp.ready);

   // Saturation, stop gating and distance accumulation
   always_comb begin
      vel_sat    = (64'(vel_prod) > 64'(VAL48_MAX)) ? VAL48_MAX : VEL_W'(vel_prod);
      if (prod_ev.stopped) begin
         vel_sat = '0;
      end
      dist_sum   = SUM_W'(dist_acc_ff) + SUM_W'(dist_prod);
      dist_sat   = (dist_sum > SUM_W'(VAL48_MAX)) ? VAL48_MAX : DIST_W'(dist_sum);
      pulses_sat = (32'(prod_count) > 32'(PULSES_MAX)) ? PULSES_MAX
                                                       : PULSES_W'(prod_count);
   end

   // Output valid and accumulator next state; a clear transaction yields no result
   always_comb begin
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      dist_acc_in  = dist_acc_ff;
      if (prod_take) begin
         if (prod_ev.clear) begin
            dist_acc_in = '0;
         end else begin
            dist_acc_in  = dist_sat;
            rsp_valid_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         dist_acc_ff  <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         dist_acc_ff  <= dist_acc_in;
      end
   end

   always_ff @(posedge clock) begin
      if (prod_take && !prod_ev.clear) begin
         velocity_ff <= vel_sat;
         distance_ff <= dist_sat;
         pulses_ff   <= pulses_sat;
         stopped_ff  <= prod_ev.stopped;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.velocity      = velocity_ff;
   assign rsp.distance      = distance_ff;
   assign rsp.window_pulses = pulses_ff;
   assign rsp.stopped       = stopped_ff;

endmodule

// File: hdl/wheel_encoder_speed_meter.sv
// Channel  Dir  Payload                                             Transaction when
// req      in   command, edge_req                                   req.valid && req.ready
// rsp      out  velocity, distance, window_pulses, stopped          rsp.valid && rsp.ready
// csr      in   csr_index, csr_wr_data                              csr_wr_en
//
// One tick is taken every cycle while req.ready is high; the counters update on
// the accepting edge. A window-closing tick passes, after its accepting edge,
// through the counter stage, the multiplier stage (count times per-edge
// constants) and the accumulate/saturate stage before its result shows on rsp.
// Synchronous reset clears all counters, the distance and the pipeline valids,
// and loads the register defaults. A stalled rsp holds its result while the
// stages behind it keep filling; req.ready drops only when every stage is full.
module wheel_encoder_speed_meter
   import wesm_pkg::*;
#(
   parameter int COUNT_WIDTH        = 16,
   parameter int TICK_COUNTER_WIDTH = 24
) (
   input  logic                  clock,
   input  logic                  reset,
   wesm_req_if.sink              req,
   wesm_rsp_if.source            rsp,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   cfg_type                         cfg;
   event_type                       ev;
   logic [COUNT_WIDTH-1:0]          ev_count;
   logic                            ev_take;
   event_type                       prod_ev;
   logic [COUNT_WIDTH-1:0]          prod_count;
   logic [COUNT_WIDTH+VPP_W-1:0]    vel_prod;
   logic [COUNT_WIDTH+CFG_W-1:0]    dist_prod;
   logic                            prod_take;

   wesm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cfg         (cfg)
   );

   wesm_window_counter #(
      .COUNT_WIDTH        (COUNT_WIDTH),
      .TICK_COUNTER_WIDTH (TICK_COUNTER_WIDTH)
   ) u_counter (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .cfg      (cfg),
      .ev_take  (ev_take),
      .ev       (ev),
      .ev_count (ev_count)
   );

   wesm_product #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_product (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ev         (ev),
      .ev_count   (ev_count),
      .ev_take    (ev_take),
      .prod_take  (prod_take),
      .prod_ev    (prod_ev),
      .prod_count (prod_count),
      .vel_prod   (vel_prod),
      .dist_prod  (dist_prod)
   );

   wesm_result #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_result (
      .clock      (clock),
      .reset      (reset),
      .prod_ev    (prod_ev),
      .prod_count (prod_count),
      .vel_prod   (vel_prod),
      .dist_prod  (dist_prod),
      .prod_take  (prod_take),
      .rsp        (rsp)
   );

endmodule

// File: bench/wheel_encoder_speed_meter_test.sv
`timescale 1ns / 1ps

module wheel_encoder_speed_meter_test;
   import wesm_pkg::*;

   localparam int LATENCY_SLACK = 8;
   localparam int LIMIT_CYCLES  = 100000;
   localparam int SHOWN_ERRORS  = 10;

   // One window report as the block should deliver it
   typedef struct packed {
      logic [VEL_W-1:0]    velocity;
      logic [DIST_W-1:0]   distance;
      logic [PULSES_W-1:0] pulses;
      logic                stopped;
   } speed_report_type;

   logic clock = 1'b0;
   logic reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   wesm_req_if req_if ();
   wesm_rsp_if rsp_if ();

   wheel_encoder_speed_meter u_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_if),
      .rsp         (rsp_if),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // Register copy held by the predictor
   logic [CFG_W-1:0] win_len;
   logic [CFG_W-1:0] stall_limit;
   logic [CFG_W-1:0] mm_step;
   logic [VPP_W-1:0] vel_step;

   // Counter copy held by the predictor
   logic [23:0]       tick_cnt;
   logic [15:0]       edge_cnt;
   logic [24:0]       since_edge;
   logic [DIST_W-1:0] dist_acc;

   speed_report_type pending_reports[$];

   int mismatch_count  = 0;
   int reports_checked = 0;
   int ticks_sent      = 0;
   int clears_sent     = 0;
   int cycle_count     = 0;
   int send_idle_pct   = 0;
   int rsp_idle_pct    = 0;
   int hold_off_cycles = 0;

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("Timeout after %0d cycles, %0d reports outstanding",
                  cycle_count, pending_reports.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // Result side: random stalls, plus long hold-offs on request
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_if.ready <= 1'b0;
         hold_off_cycles--;
      end else begin
         rsp_if.ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   function automatic void load_reset_values();
      win_len     = WINDOW_TICKS_RST;
      stall_limit = STALL_TIMEOUT_RST;
      mm_step     = MM_PER_PULSE_RST;
      vel_step    = VEL_PER_PULSE_RST;
      tick_cnt    = '0;
      edge_cnt    = '0;
      since_edge  = '0;
      dist_acc    = '0;
   endfunction

   // Advance the counters by one tick; a closed window queues its report
   function automatic void tally_tick(logic clear_cmd, logic has_edge);
      speed_report_type rpt;
      longint unsigned vel_full;
      longint unsigned dist_full;
      if (clear_cmd) begin
         tick_cnt   = '0;
         edge_cnt   = '0;
         since_edge = '0;
         dist_acc   = '0;
         return;
      end
      if (has_edge) begin
         if (edge_cnt != '1)
            edge_cnt++;
         since_edge = '0;
      end else if (since_edge != '1) begin
         since_edge++;
      end
      if (tick_cnt != '1)
         tick_cnt++;
      // a zero length acts like one, since the count is at least one here
      if (tick_cnt < win_len)
         return;
      tick_cnt    = '0;
      rpt.stopped = (since_edge > {1'b0, stall_limit});
      vel_full    = 64'(edge_cnt) * 64'(vel_step);
      if (vel_full > 64'(VAL48_MAX))
         vel_full = 64'(VAL48_MAX);
      rpt.velocity = rpt.stopped ? '0 : vel_full[VEL_W-1:0];
      dist_full    = 64'(dist_acc) + 64'(edge_cnt) * 64'(mm_step);
      if (dist_full > 64'(VAL48_MAX))
         dist_full = 64'(VAL48_MAX);
      dist_acc     = dist_full[DIST_W-1:0];
      rpt.distance = dist_acc;
      rpt.pulses   = edge_cnt;
      edge_cnt     = '0;
      pending_reports.push_back(rpt);
   endfunction

   function automatic void flag_mismatch(string what, logic [47:0] want_v,
                                         logic [47:0] got_v);
      mismatch_count++;
      if (mismatch_count <= SHOWN_ERRORS)
         $display("Mismatch at %0t in %s: expected %0h, got %0h",
                  $realtime, what, want_v, got_v);
   endfunction

   // Compare each result transaction with the oldest queued report
   always @(posedge clock) begin
      speed_report_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_reports.size() == 0) begin
            flag_mismatch("unexpected report", '0, rsp_if.distance);
         end else begin
            want = pending_reports.pop_front();
            reports_checked++;
            if (rsp_if.velocity !== want.velocity)
               flag_mismatch("velocity", want.velocity, rsp_if.velocity);
            if (rsp_if.distance !== want.distance)
               flag_mismatch("distance", want.distance, rsp_if.distance);
            if (rsp_if.window_pulses !== want.pulses)
               flag_mismatch("window_pulses", 48'(want.pulses),
                             48'(rsp_if.window_pulses));
            if (rsp_if.stopped !== want.stopped)
               flag_mismatch("stopped", 48'(want.stopped), 48'(rsp_if.stopped));
         end
      end
   end

   // Offer one tick or clear after a random gap and wait for its transaction
   task automatic send_tick(input logic clear_cmd, input logic has_edge);
      @(negedge clock);
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid    = 1'b1;
      req_if.command  = clear_cmd;
      req_if.edge_req = has_edge;
      do
         @(posedge clock);
      while (!req_if.ready);
      tally_tick(clear_cmd, has_edge);
      if (clear_cmd)
         clears_sent++;
      else
         ticks_sent++;
   endtask

   // Stop offering, let every report arrive and the pipeline empty
   task automatic wait_idle();
      @(negedge clock);
      req_if.valid = 1'b0;
      while (pending_reports.size() != 0)
         @(posedge clock);
      repeat (LATENCY_SLACK) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_index   = idx;
      csr_wr_data = val;
      @(negedge clock);
      csr_wr_en   = 1'b0;
      case (idx)
         CSR_WINDOW_TICKS:  win_len     = val[CFG_W-1:0];
         CSR_STALL_TIMEOUT: stall_limit = val[CFG_W-1:0];
         CSR_MM_PER_PULSE:  mm_step     = val[CFG_W-1:0];
         CSR_VEL_PER_PULSE: vel_step    = val[VPP_W-1:0];
         default: ;
      endcase
   endtask

   task automatic write_all(input logic [CFG_W-1:0] wl, input logic [CFG_W-1:0] st,
                            input logic [CFG_W-1:0] mm, input logic [VPP_W-1:0] vp);
      write_reg(CSR_WINDOW_TICKS, 32'(wl));
      write_reg(CSR_STALL_TIMEOUT, 32'(st));
      write_reg(CSR_MM_PER_PULSE, 32'(mm));
      write_reg(CSR_VEL_PER_PULSE, vp);
   endtask

   // Reset values: the long default window stays open, then a shorter window
   // closes with the default timeout and rates
   task automatic test_reset_defaults();
      for (int i = 0; i < 60; i++)
         send_tick(1'b0, (i % 7) == 0);
      wait_idle();
      write_reg(CSR_WINDOW_TICKS, 32'd100);
      for (int i = 60; i < 100; i++)
         send_tick(1'b0, (i % 7) == 0);
      wait_idle();
   endtask

   // Every tick closes a window; zero timeout marks edge-free ticks stopped
   task automatic test_single_tick_windows();
      write_all(24'd1, 24'd0, 24'hFFFFFF, 32'hFFFFFFFF);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b0);
      wait_idle();
      write_reg(CSR_WINDOW_TICKS, 32'd0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      wait_idle();
   endtask

   // Clears mid-window and at a window start, the first with the edge flag set to show it is ignored
   task automatic test_clear_command();
      write_all(24'd4, 24'd100, 24'd40554, 32'd811082);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b0, 1'b0);
      send_tick(1'b0, 1'b1);
      send_tick(1'b1, 1'b0);
      wait_idle();
   endtask

   // Long window cut short below the current count closes on the next tick
   task automatic test_window_shortened();
      write_reg(CSR_WINDOW_TICKS, 32'hFFFFFF);
      for (int i = 0; i < 12; i++)
         send_tick(1'b0, i[0]);
      wait_idle();
      write_reg(CSR_WINDOW_TICKS, 32'd3);
      send_tick(1'b0, 1'b1);
      wait_idle();
   endtask

   // Edges early in a window longer than the timeout, plus zero rates
   task automatic test_stopped_with_edges();
      write_all(24'd10, 24'd3, 24'd1000, 32'd65536);
      for (int i = 0; i < 20; i++)
         send_tick(1'b0, i == 0 || i == 1 || i == 10);
      wait_idle();
      write_reg(CSR_MM_PER_PULSE, 32'd0);
      write_reg(CSR_VEL_PER_PULSE, 32'd0);
      for (int i = 0; i < 10; i++)
         send_tick(1'b0, 1'b1);
      wait_idle();
   endtask

   // A window full of edges with the largest per-edge rates
   task automatic test_large_rates();
      write_all(24'd120, 24'hFFFFFF, 24'hFFFFFF, 32'hFFFFFFFF);
      for (int i = 0; i < 120; i++)
         send_tick(1'b0, 1'b1);
      wait_idle();
   endtask

   // Receiver holds off while ticks keep coming, so the block backs up
   task automatic test_back_pressure();
      write_all(24'd1, 24'd2, 24'd12345, 32'd987654);
      @(posedge clock);
      hold_off_cycles = 300;
      for (int i = 0; i < 60; i++)
         send_tick(1'b0, 1'($urandom_range(1)));
      wait_idle();
   endtask

   // Random register settings, edge density and occasional clears
   task automatic test_random_traffic(input int n_items);
      int done;
      int edge_pct;
      int burst;
      logic [CFG_W-1:0] wl;
      logic [CFG_W-1:0] st;
      logic [CFG_W-1:0] mm;
      logic [VPP_W-1:0] vp;
      done = 0;
      while (done < n_items) begin
         case ($urandom_range(15))
            0:       wl = '0;
            1:       wl = 24'd1;
            2:       wl = 24'($urandom_range(100, 300));
            default: wl = 24'($urandom_range(2, 20));
         endcase
         case ($urandom_range(7))
            0:       st = '0;
            1:       st = '1;
            default: st = 24'($urandom_range(1, 40));
         endcase
         case ($urandom_range(5))
            0:       mm = '0;
            1:       mm = '1;
            default: mm = 24'($urandom);
         endcase
         case ($urandom_range(5))
            0:       vp = '0;
            1:       vp = '1;
            default: vp = $urandom;
         endcase
         write_all(wl, st, mm, vp);
         edge_pct = $urandom_range(100);
         burst    = $urandom_range(60, 160);
         repeat (burst) begin
            if ($urandom_range(99) < 2)
               send_tick(1'b1, 1'($urandom_range(1)));
            else
               send_tick(1'b0, $urandom_range(99) < edge_pct);
            done++;
         end
         wait_idle();
      end
   endtask

   initial begin
      reset           = 1'b1;
      req_if.valid    = 1'b0;
      req_if.command  = 1'b0;
      req_if.edge_req = 1'b0;
      rsp_if.ready    = 1'b0;
      csr_wr_en       = 1'b0;
      csr_index       = CSR_WINDOW_TICKS;
      csr_wr_data     = '0;
      load_reset_values();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      send_idle_pct = 29;
      rsp_idle_pct  = 49;
      test_reset_defaults();
      test_single_tick_windows();
      test_clear_command();
      test_window_shortened();
      test_stopped_with_edges();
      test_random_traffic(250);

      send_idle_pct = 49;
      rsp_idle_pct  = 29;
      test_random_traffic(250);

      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      test_random_traffic(250);
      test_back_pressure();
      test_large_rates();

      $display("Sent %0d ticks and %0d clears; checked %0d window reports",
               ticks_sent, clears_sent, reports_checked);
      $display("Covered zero/one/long/shortened windows, timeouts, large rates, back-pressure");
      if (mismatch_count == 0 && pending_reports.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("%0d mismatches, %0d reports missing", mismatch_count,
                  pending_reports.size());
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// File: wheel_encoder_speed_meter.f
hdl/wesm_pkg.sv
hdl/wesm_req_if.sv
hdl/wesm_rsp_if.sv
hdl/wesm_csr.sv
hdl/wesm_window_counter.sv
hdl/wesm_product.sv
hdl/wesm_result.sv
hdl/wheel_encoder_speed_meter.sv
bench/wheel_encoder_speed_meter_test.sv
